// ===== sv/bpc_pkg.sv =====
// Shared types and constants for the button press classifier
`default_nettype none

package bpc_pkg;

    localparam int unsigned LEVEL_W = 1;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned UNIT_W  = 16;
    localparam int unsigned THR_W   = 20;
    localparam int unsigned EVENT_W = 3;

    localparam logic [LEVEL_W-1:0] ACTIVE_LEVEL_RST = 1'b0;
    localparam logic [UNIT_W-1:0]  UNIT_MS_RST      = 16'd100;

    typedef enum logic [0:0] {
        CFG_ACTIVE_LEVEL = 1'b0,
        CFG_UNIT_MS      = 1'b1
    } t_cfg_idx;

    typedef enum logic [EVENT_W-1:0] {
        EV_IDLE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_SHORT   = 3'd2,
        EV_DOUBLE  = 3'd3,
        EV_LONG    = 3'd4,
        EV_KEEP    = 3'd5,
        EV_RELEASE = 3'd6
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SHORT   = 3'd1,
        PH_DOUBLE  = 3'd2,
        PH_LONG    = 3'd3,
        PH_KEEP    = 3'd4,
        PH_RELEASE = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        UNITS_1  = 2'd0,
        UNITS_2  = 2'd1,
        UNITS_5  = 2'd2,
        UNITS_10 = 2'd3
    } t_units;

    typedef struct packed {
        logic [LEVEL_W-1:0] pin_level;
        logic [TIME_W-1:0]  now_ms;
    } t_poll;

    typedef struct packed {
        logic   call;
        logic   clear;
        logic   changed;
        t_units units;
    } t_tmr_req;

endpackage

`default_nettype wire

// ===== sv/bpc_poll_if.sv =====
// Poll channel: valid, ready and the sampled pin level with its timestamp
`default_nettype none

interface bpc_poll_if;
    logic        valid;
    logic        ready;
    logic [0:0]  pin_level;
    logic [31:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

`default_nettype wire

// ===== sv/bpc_event_if.sv =====
// Event channel: valid, ready and the classified event code
`default_nettype none

interface bpc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

`default_nettype wire

// ===== sv/bpc_in_stage.sv =====
// Input register for poll transactions
`default_nettype none

module bpc_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    bpc_poll_if.sink           i_poll,
    output bpc_pkg::t_poll     o_poll,
    output logic               o_valid
);
    import bpc_pkg::*;

    logic  r_valid;
    t_poll r_poll;
    logic  w_load;

    assign w_load       = !r_valid || i_advance;
    assign i_poll.ready = w_load;
    assign o_poll       = r_poll;
    assign o_valid      = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_poll.valid) begin
            r_poll.pin_level <= i_poll.pin_level;
            r_poll.now_ms    <= i_poll.now_ms;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bpc_timer.sv =====
// Debounce timer: start stamp, running flag and the two rearm flags
`default_nettype none

module bpc_timer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire bpc_pkg::t_tmr_req             i_req,
    input  wire logic [bpc_pkg::TIME_W-1:0]    i_now_ms,
    input  wire logic [bpc_pkg::UNIT_W-1:0]    i_unit_ms,
    output logic                               o_expired
);
    import bpc_pkg::*;

    logic              r_run;
    logic              r_eq;
    logic              r_uneq;
    logic [TIME_W-1:0] r_start;
    logic              n_run;
    logic              n_eq;
    logic              n_uneq;
    logic [TIME_W-1:0] n_start;

    logic [THR_W-1:0]  w_unit;
    logic [THR_W-1:0]  w_thr;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_eff_run;

    assign w_unit    = {{(THR_W-UNIT_W){1'b0}}, i_unit_ms};
    assign w_elapsed = i_now_ms - r_start;
    assign w_eff_run = i_req.changed ? (r_run && !r_uneq) : (r_run && !r_eq);

    always_comb begin
        case (i_req.units)
            UNITS_1:  w_thr = w_unit;
            UNITS_2:  w_thr = w_unit << 1;
            UNITS_5:  w_thr = (w_unit << 2) + w_unit;
            UNITS_10: w_thr = (w_unit << 3) + (w_unit << 1);
            default:  w_thr = w_unit;
        endcase
    end

    assign o_expired = i_req.call && w_eff_run &&
                       (w_elapsed >= {{(TIME_W-THR_W){1'b0}}, w_thr});

    always_comb begin
        n_run   = r_run;
        n_eq    = r_eq;
        n_uneq  = r_uneq;
        n_start = r_start;
        if (i_req.call) begin
            n_eq   = i_req.changed;
            n_uneq = !i_req.changed;
            if (!w_eff_run) begin
                n_run   = 1'b1;
                n_start = i_now_ms;
            end else begin
                n_run = !o_expired;
            end
        end else if (i_req.clear) begin
            n_run = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_eq    <= 1'b0;
            r_uneq  <= 1'b0;
            r_start <= '0;
        end else if (i_step) begin
            r_run   <= n_run;
            r_eq    <= n_eq;
            r_uneq  <= n_uneq;
            r_start <= n_start;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bpc_fsm.sv =====
// Press classification state machine
`default_nettype none

module bpc_fsm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire bpc_pkg::t_poll                i_poll,
    input  wire logic [bpc_pkg::LEVEL_W-1:0]   i_active_level,
    input  wire logic                          i_expired,
    output bpc_pkg::t_tmr_req                  o_req,
    output bpc_pkg::t_event                    o_event
);
    import bpc_pkg::*;

    t_phase r_phase;
    logic   r_rec;
    t_event r_last;
    t_phase n_phase;
    logic   n_rec;
    t_event n_event;

    logic   w_cur;
    logic   w_changed;

    assign w_cur     = (i_poll.pin_level == i_active_level);
    assign w_changed = (w_cur != r_rec);
    assign o_event   = n_event;

    always_comb begin
        o_req.call    = 1'b1;
        o_req.clear   = 1'b0;
        o_req.changed = w_changed;
        o_req.units   = UNITS_1;
        case (r_phase)
            PH_IDLE: begin
                if (!w_changed) begin
                    o_req.call  = 1'b0;
                    o_req.clear = 1'b1;
                end
            end
            PH_RELEASE, PH_DOUBLE: begin
                if (!w_changed) begin
                    o_req.units = UNITS_2;
                end
            end
            PH_SHORT: begin
                if (!w_changed) begin
                    o_req.units = UNITS_10;
                end
            end
            PH_LONG, PH_KEEP: begin
                if (!w_changed) begin
                    o_req.units = UNITS_5;
                end
            end
            default: begin
                o_req.call = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase       = r_phase;
        n_rec         = r_rec;
        n_event       = EV_IDLE;
        case (r_phase)
            PH_IDLE: begin
                if (w_changed) begin
                    if (i_expired) begin
                        n_phase = PH_SHORT;
                        n_rec   = w_cur;
                    end
                end
            end
            PH_RELEASE: begin
                if (w_changed) begin
                    if (i_expired) begin
                        n_phase = PH_SHORT;
                        n_rec   = w_cur;
                    end
                end else begin
                    if (i_expired) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_SHORT: begin
                if (w_changed) begin
                    if (i_expired) begin
                        n_phase = PH_DOUBLE;
                        n_rec   = w_cur;
                    end
                end else begin
                    if (r_last != EV_PRESS) begin
                        n_event = EV_PRESS;
                    end
                    if (i_expired) begin
                        n_phase = PH_LONG;
                        n_rec   = w_cur;
                    end
                end
            end
            PH_DOUBLE: begin
                if (w_changed) begin
                    if (i_expired) begin
                        n_phase = PH_KEEP;
                        n_event = EV_DOUBLE;
                        n_rec   = w_cur;
                    end
                end else begin
                    if (i_expired) begin
                        n_phase = PH_IDLE;
                        n_event = EV_SHORT;
                    end
                end
            end
            PH_LONG: begin
                if (w_changed) begin
                    if (i_expired) begin
                        n_phase = PH_IDLE;
                        n_rec   = w_cur;
                    end
                end else begin
                    if (r_last == EV_PRESS) begin
                        n_event = EV_PRESS;
                    end
                    if (i_expired) begin
                        n_phase = PH_KEEP;
                        n_event = EV_LONG;
                    end
                end
            end
            PH_KEEP: begin
                if (w_changed) begin
                    if (i_expired) begin
                        n_phase = PH_RELEASE;
                        n_event = EV_RELEASE;
                        n_rec   = w_cur;
                    end
                end else begin
                    if (i_expired) begin
                        n_event = EV_KEEP;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rec   <= 1'b0;
            r_last  <= EV_IDLE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_rec   <= n_rec;
            r_last  <= n_event;
        end
    end

endmodule

`default_nettype wire

// ===== sv/bpc_out_stage.sv =====
// Result register for event transactions
`default_nettype none

module bpc_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire bpc_pkg::t_event   i_event,
    output logic                   o_advance,
    bpc_event_if.source            o_event
);
    import bpc_pkg::*;

    logic   r_valid;
    t_event r_event;

    assign o_advance          = !r_valid || o_event.ready;
    assign o_event.valid      = r_valid;
    assign o_event.event_code = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_event <= i_event;
        end
    end

endmodule

`default_nettype wire

// ===== sv/button_press_classifier.sv =====
// Top level of the button press classifier
//
//   channel   dir  transaction payload
//   i_poll    in   pin_level[0:0], now_ms[31:0]
//   o_event   out  event_code[2:0]
//   i_cfg_*   in   idx 0 active_level, idx 1 debounce_unit_ms
//
// One poll per clock unless the result stalls; each poll yields one registered event.
// The state update sits between the input register and the result register.
// Reset: classifier idle, key taken as released, unit 100 ms, active level 0.
// A stalled result holds both registers; the input side keeps filling an empty slot.
`default_nettype none

module button_press_classifier (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    bpc_poll_if.sink                           i_poll,
    bpc_event_if.source                        o_event,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_idx,
    input  wire logic [bpc_pkg::UNIT_W-1:0]    i_cfg_data
);
    import bpc_pkg::*;

    logic [LEVEL_W-1:0] r_active_level;
    logic [UNIT_W-1:0]  r_unit_ms;

    t_poll    w_poll;
    logic     w_poll_valid;
    logic     w_advance;
    logic     w_step;
    logic     w_expired;
    t_tmr_req w_req;
    t_event   w_event;

    assign w_step = w_advance && w_poll_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= ACTIVE_LEVEL_RST;
            r_unit_ms      <= UNIT_MS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_UNIT_MS:      r_unit_ms      <= i_cfg_data;
                default:          r_unit_ms      <= r_unit_ms;
            endcase
        end
    end

    bpc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_poll    (i_poll),
        .o_poll    (w_poll),
        .o_valid   (w_poll_valid)
    );

    bpc_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_req     (w_req),
        .i_now_ms  (w_poll.now_ms),
        .i_unit_ms (r_unit_ms),
        .o_expired (w_expired)
    );

    bpc_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_poll         (w_poll),
        .i_active_level (r_active_level),
        .i_expired      (w_expired),
        .o_req          (w_req),
        .o_event        (w_event)
    );

    bpc_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_poll_valid),
        .i_event   (w_event),
        .o_advance (w_advance),
        .o_event   (o_event)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the button press classifier: directed and random polls
`default_nettype none

module testbench;
    import bpc_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned FAULT_PRINT_MAX = 50;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    t_cfg_idx cfg_idx;
    logic [UNIT_W-1:0] cfg_data;

    bpc_poll_if  poll_ch ();
    bpc_event_if event_ch ();

    button_press_classifier dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_poll     (poll_ch),
        .o_event    (event_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // classifier state as the testbench sees it
    logic              cfg_active = ACTIVE_LEVEL_RST;
    logic [UNIT_W-1:0] cfg_unit = UNIT_MS_RST;
    t_phase            cls_phase = PH_IDLE;
    logic              held_level = 1'b0;
    logic              tmr_on = 1'b0;
    logic [31:0]       tmr_start = '0;
    logic              eq_armed = 1'b0;
    logic              ne_armed = 1'b0;
    t_event            prev_event = EV_IDLE;

    t_event      pending_events [$];
    int unsigned polls_sent = 0;
    int unsigned events_seen = 0;
    int unsigned fault_count = 0;
    int unsigned quiet_cycles = 0;
    logic        steady = 1'b0;

    function automatic logic tmr_check(input logic [31:0] stamp, input int unsigned mult);
        logic [31:0] span;
        if (!tmr_on) begin
            tmr_start = stamp;
            tmr_on = 1'b1;
            return 1'b0;
        end
        span = stamp - tmr_start;
        if (span >= cfg_unit * mult) begin
            tmr_on = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic hold_wait(input logic [31:0] stamp, input int unsigned mult);
        if (eq_armed) begin
            tmr_on = 1'b0;
            eq_armed = 1'b0;
        end
        ne_armed = 1'b1;
        return tmr_check(stamp, mult);
    endfunction

    function automatic logic move_wait(input logic [31:0] stamp, input int unsigned mult);
        if (ne_armed) begin
            tmr_on = 1'b0;
            ne_armed = 1'b0;
        end
        eq_armed = 1'b1;
        return tmr_check(stamp, mult);
    endfunction

    function automatic t_event classify_poll(input logic pin, input logic [31:0] stamp);
        logic   active;
        logic   moved;
        t_event ev;
        active = (pin == cfg_active);
        moved = (active != held_level);
        ev = EV_IDLE;
        case (cls_phase)
            PH_IDLE: begin
                if (moved) begin
                    if (move_wait(stamp, 1)) begin
                        cls_phase = PH_SHORT;
                        held_level = active;
                    end
                end else begin
                    tmr_on = 1'b0;
                end
            end
            PH_RELEASE: begin
                if (moved) begin
                    if (move_wait(stamp, 1)) begin
                        cls_phase = PH_SHORT;
                        held_level = active;
                    end
                end else if (hold_wait(stamp, 2)) begin
                    cls_phase = PH_IDLE;
                end
            end
            PH_SHORT: begin
                if (moved) begin
                    if (move_wait(stamp, 1)) begin
                        cls_phase = PH_DOUBLE;
                        held_level = active;
                    end
                end else begin
                    if (prev_event != EV_PRESS) ev = EV_PRESS;
                    if (hold_wait(stamp, 10)) begin
                        cls_phase = PH_LONG;
                        held_level = active;
                    end
                end
            end
            PH_DOUBLE: begin
                if (moved) begin
                    if (move_wait(stamp, 1)) begin
                        cls_phase = PH_KEEP;
                        ev = EV_DOUBLE;
                        held_level = active;
                    end
                end else if (hold_wait(stamp, 2)) begin
                    cls_phase = PH_IDLE;
                    ev = EV_SHORT;
                end
            end
            PH_LONG: begin
                if (moved) begin
                    if (move_wait(stamp, 1)) begin
                        cls_phase = PH_IDLE;
                        held_level = active;
                    end
                end else begin
                    if (prev_event == EV_PRESS) ev = EV_PRESS;
                    if (hold_wait(stamp, 5)) begin
                        cls_phase = PH_KEEP;
                        ev = EV_LONG;
                    end
                end
            end
            PH_KEEP: begin
                if (moved) begin
                    if (move_wait(stamp, 1)) begin
                        cls_phase = PH_RELEASE;
                        ev = EV_RELEASE;
                        held_level = active;
                    end
                end else if (hold_wait(stamp, 5)) begin
                    ev = EV_KEEP;
                    tmr_on = 1'b0;
                end
            end
            default: ;
        endcase
        prev_event = ev;
        return ev;
    endfunction

    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= FAULT_PRINT_MAX) $display("mismatch: %s", what);
    endtask

    always @(posedge clk) begin
        event_ch.ready <= steady || ($urandom_range(99) >= 8);
    end

    // predict on each accepted poll, then check each accepted event
    always @(posedge clk) begin
        t_event want;
        if (rst_n && poll_ch.valid && poll_ch.ready)
            pending_events.push_back(classify_poll(poll_ch.pin_level[0], poll_ch.now_ms));
        if (rst_n && event_ch.valid && event_ch.ready) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                report_fault($sformatf("event %0d with none expected", event_ch.event_code));
            end else begin
                want = pending_events.pop_front();
                if (event_ch.event_code !== want)
                    report_fault($sformatf("event_code %0d, expected %0d (%s)",
                                           event_ch.event_code, want, want.name()));
            end
        end
        if ((poll_ch.valid && poll_ch.ready) || (event_ch.valid && event_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_poll(input logic pin, input logic [31:0] stamp);
        while (!steady && $urandom_range(99) < 8) begin
            poll_ch.valid <= 1'b0;
            @(posedge clk);
        end
        poll_ch.valid     <= 1'b1;
        poll_ch.pin_level <= pin;
        poll_ch.now_ms    <= stamp;
        @(posedge clk);
        while (!poll_ch.ready) @(posedge clk);
        polls_sent++;
    endtask

    task automatic wait_drained();
        poll_ch.valid <= 1'b0;
        while (events_seen != polls_sent) @(posedge clk);
    endtask

    task automatic apply_config(input logic active, input logic [UNIT_W-1:0] unit);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ACTIVE_LEVEL;
        cfg_data <= {{(UNIT_W-1){1'b0}}, active};
        @(posedge clk);
        cfg_active = active;
        cfg_idx  <= CFG_UNIT_MS;
        cfg_data <= unit;
        @(posedge clk);
        cfg_unit = unit;
        cfg_we <= 1'b0;
    endtask

    task automatic run_random_polls(input int unsigned count);
        logic        level;
        logic [31:0] stamp;
        int unsigned run_left;
        int unsigned span;
        level = 1'($urandom_range(1));
        stamp = $urandom;
        run_left = 0;
        repeat (count) begin
            if (run_left == 0) begin
                level = ~level;
                run_left = ($urandom_range(3) == 0) ? $urandom_range(40, 10)
                                                    : $urandom_range(8, 1);
            end
            run_left--;
            span = cfg_unit * 3;
            case ($urandom_range(19))
                0:       stamp = $urandom;
                1, 2:    stamp += $urandom_range(cfg_unit / 4 + 1);
                default: stamp += $urandom_range(span + 2);
            endcase
            // bounce: flip the pin for a single poll
            if ($urandom_range(99) < 10)
                send_poll(~level, stamp);
            else
                send_poll(level, stamp);
        end
    endtask

    // reset settings: pin low is pressed, 100 ms unit
    task automatic test_default_config();
        send_poll(1'b1, 32'd0);
        send_poll(1'b0, 32'd10);
        send_poll(1'b0, 32'd110);
        send_poll(1'b0, 32'd120);
        send_poll(1'b0, 32'd130);
        send_poll(1'b0, 32'd1120);
        send_poll(1'b0, 32'd1130);
        send_poll(1'b0, 32'd1630);
        send_poll(1'b0, 32'd1640);
        send_poll(1'b0, 32'd2140);
        send_poll(1'b1, 32'd2150);
        send_poll(1'b1, 32'd2250);
        send_poll(1'b0, 32'd2260);
        send_poll(1'b0, 32'd2360);
        send_poll(1'b1, 32'd2370);
        send_poll(1'b1, 32'd2470);
        send_poll(1'b1, 32'd2480);
        send_poll(1'b1, 32'd2680);
    endtask

    // widest unit with the timestamp wrapping through zero, ending in a double press
    task automatic test_wrap_double();
        logic [31:0] base;
        base = 32'hFFFF_FF00;
        apply_config(1'b1, 16'hFFFF);
        send_poll(1'b1, base);
        send_poll(1'b1, base + 32'd65535);
        send_poll(1'b0, base + 32'd65600);
        send_poll(1'b0, base + 32'd131135);
        send_poll(1'b1, base + 32'd131200);
        send_poll(1'b1, base + 32'd196735);
    endtask

    task automatic test_random_sweep();
        apply_config(1'b0, 16'd1);
        run_random_polls(300);
        apply_config(1'b1, 16'd3);
        steady <= 1'b1;
        run_random_polls(300);
        steady <= 1'b0;
        apply_config(1'b0, 16'd0);
        run_random_polls(300);
        apply_config(1'b1, 16'hFFFF);
        run_random_polls(300);
        apply_config(1'b0, 16'd100);
        run_random_polls(300);
        apply_config(1'b1, 16'd7);
        run_random_polls(300);
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_ACTIVE_LEVEL;
        cfg_data = '0;
        poll_ch.valid = 1'b0;
        poll_ch.pin_level = 1'b0;
        poll_ch.now_ms = '0;
        event_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_default_config();
        test_wrap_double();
        test_random_sweep();
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_events.size() != 0)
            report_fault($sformatf("%0d events never arrived", pending_events.size()));
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
sv/bpc_pkg.sv
sv/bpc_poll_if.sv
sv/bpc_event_if.sv
sv/bpc_in_stage.sv
sv/bpc_timer.sv
sv/bpc_fsm.sv
sv/bpc_out_stage.sv
sv/button_press_classifier.sv
tb/testbench.sv
